FILE: design/iss_pkg.sv
`default_nettype none
package iss_pkg;

  localparam logic [1:0] FUNC_CLEAR   = 2'd0;
  localparam logic [1:0] FUNC_INSERT  = 2'd1;
  localparam logic [1:0] FUNC_EXCLUDE = 2'd2;
  localparam logic [1:0] FUNC_READ    = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_IDX  = 2'd2;

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] S_IDLE  = 3'd0;
  localparam logic [STATE_W-1:0] S_CMD   = 3'd1;
  localparam logic [STATE_W-1:0] S_RWAIT = 3'd2;
  localparam logic [STATE_W-1:0] S_XRD   = 3'd3;
  localparam logic [STATE_W-1:0] S_XEV   = 3'd4;
  localparam logic [STATE_W-1:0] S_XSPL  = 3'd5;
  localparam logic [STATE_W-1:0] S_FIN   = 3'd6;

endpackage
`default_nettype wire

FILE: design/interval_set_subtract_unit.sv
`default_nettype none
// channel | dir | handshake                 | payload
// in_     | in  | in_tvalid / in_tready      | in_tdata: func, range_begin, range_end, entry_index
// out_    | out | out_tvalid / out_tready    | out_tdata: status, entry_begin, entry_end, range_count
// Clear and insert go from the command to the finish state; a read in range adds a RAM wait state.
// Exclude puts each entry through one registered RAM read and one shared compare step, two if split.
// The list lives in two RAM banks; an exclusion copies it from one bank into the other.
// rst_n (sync, active low) empties the list; RAM contents need no clearing.
// in_tready is high only in idle; a stalled result waits in the output register.
module interval_set_subtract_unit #(
  parameter int RANGE_SLOTS = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // func[1:0], range_begin[33:2], range_end[65:34],
                                       // entry_index[70:66], zero[71]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [71:0] out_tdata   // status[1:0], entry_begin[33:2], entry_end[65:34],
                                       // range_count[71:66]
);

  localparam int VW = VALUE_WIDTH;
  localparam int AW = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
  localparam int CW = $clog2(RANGE_SLOTS + 1);
  localparam int EW = (VW > 32) ? VW : 32;
  localparam int IW = (CW > 5) ? CW : 5;
  localparam int DW = 2 * VW;

  logic [iss_pkg::STATE_W-1:0] state_r;
  logic [1:0]                  func_r;
  logic signed [VW-1:0]        lo_r, hi_r, spl_e_r;
  logic [4:0]                  idx_r;
  logic [1:0]                  st_r;
  logic signed [VW-1:0]        eb_r, ee_r;
  logic [CW-1:0]               held_r, n_r, c_r, w_r;
  logic [AW-1:0]               head_r;
  logic                        bank_r;
  logic                        out_valid_r;
  logic [71:0]                 out_data_r;

  // input field extraction
  logic signed [31:0] in_b32, in_e32;
  logic signed [EW-1:0] in_bx, in_ex;
  assign in_b32 = in_tdata[33:2];
  assign in_e32 = in_tdata[65:34];
  assign in_bx  = in_b32;
  assign in_ex  = in_e32;

  // logical to physical slot
  logic [CW-1:0]  rd_k;
  logic [AW:0]    rd_sum;
  logic [AW-1:0]  rd_addr;
  assign rd_k = (state_r == iss_pkg::S_CMD) ? CW'(idx_r) : c_r;
  always_comb begin
    rd_sum = {1'b0, head_r} + (AW+1)'(rd_k);
    if (rd_sum >= (AW+1)'(RANGE_SLOTS)) begin
      rd_sum = rd_sum - (AW+1)'(RANGE_SLOTS);
    end
  end
  assign rd_addr = rd_sum[AW-1:0];

  logic [DW-1:0] rd0, rd1, rd_data;
  logic signed [VW-1:0] rb, re;
  assign rd_data = bank_r ? rd1 : rd0;
  assign rb = rd_data[VW-1:0];
  assign re = rd_data[DW-1:VW];

  // S_XSPL re-checks the upper piece of a split before the walk moves on
  logic x_eval;
  logic signed [VW-1:0] cmp_b, cmp_e;
  assign x_eval = (state_r == iss_pkg::S_XEV) || (state_r == iss_pkg::S_XSPL);
  assign cmp_b  = (state_r == iss_pkg::S_XSPL) ? hi_r + VW'(1) : rb;
  assign cmp_e  = (state_r == iss_pkg::S_XSPL) ? spl_e_r : re;

  // shared compare step
  logic c_all, c_low, c_high, c_mid, c_split, room;
  logic [CW:0] held_now;
  assign c_all   = (lo_r <= cmp_b) && (hi_r >= cmp_e);
  assign c_low   = (lo_r <= cmp_b) && (hi_r >= cmp_b) && (hi_r < cmp_e);
  assign c_high  = (lo_r >= cmp_b) && (lo_r <= cmp_e) && (hi_r >= cmp_e);
  assign c_mid   = (lo_r > cmp_b) && (hi_r < cmp_e);
  assign c_split = !c_all && !c_low && !c_high && c_mid;
  assign held_now = (CW+1)'(w_r) + (CW+1)'(n_r) - (CW+1)'(c_r);
  assign room = held_now < (CW+1)'(RANGE_SLOTS);

  logic full;
  logic [AW-1:0] head_dec;
  assign full = held_r >= CW'(RANGE_SLOTS);
  assign head_dec = (head_r == '0) ? AW'(RANGE_SLOTS - 1) : head_r - AW'(1);

  logic [IW-1:0] idx_x, held_x;
  assign idx_x  = IW'(idx_r);
  assign held_x = IW'(held_r);

  // write port
  logic          wr_en, wr_bank;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  always_comb begin
    wr_en   = 1'b0;
    wr_bank = ~bank_r;
    wr_addr = w_r[AW-1:0];
    wr_data = {cmp_e, cmp_b};
    if (x_eval) begin
      wr_en = !c_all;
      if (c_low) begin
        wr_data = {cmp_e, hi_r + VW'(1)};
      end else if (c_high || (c_mid && room)) begin
        wr_data = {lo_r - VW'(1), cmp_b};
      end
    end else if (state_r == iss_pkg::S_CMD && func_r == iss_pkg::FUNC_INSERT && !full) begin
      wr_en   = 1'b1;
      wr_bank = bank_r;
      wr_addr = head_dec;
      wr_data = {hi_r, lo_r};
    end
  end

  iss_ram #(.WIDTH(DW), .DEPTH(RANGE_SLOTS)) u_bank0 (
    .clk(clk), .we(wr_en && !wr_bank), .waddr(wr_addr), .wdata(wr_data),
    .raddr(rd_addr), .rdata(rd0)
  );
  iss_ram #(.WIDTH(DW), .DEPTH(RANGE_SLOTS)) u_bank1 (
    .clk(clk), .we(wr_en && wr_bank), .waddr(wr_addr), .wdata(wr_data),
    .raddr(rd_addr), .rdata(rd1)
  );

  logic signed [EW-1:0] eb_x, ee_x;
  logic [5:0] cnt6;
  assign eb_x = eb_r;
  assign ee_x = ee_r;
  assign cnt6 = 6'(held_r);

  assign in_tready  = (state_r == iss_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iss_pkg::S_IDLE;
      held_r      <= '0;
      head_r      <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != iss_pkg::S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        iss_pkg::S_IDLE: begin
          if (in_tvalid) begin
            func_r  <= in_tdata[1:0];
            lo_r    <= in_bx[VW-1:0];
            hi_r    <= in_ex[VW-1:0];
            idx_r   <= in_tdata[70:66];
            state_r <= iss_pkg::S_CMD;
          end
        end
        iss_pkg::S_CMD: begin
          eb_r <= '0;
          ee_r <= '0;
          unique case (func_r)
            iss_pkg::FUNC_CLEAR: begin
              st_r    <= iss_pkg::ST_OK;
              held_r  <= '0;
              head_r  <= '0;
              state_r <= iss_pkg::S_FIN;
            end
            iss_pkg::FUNC_INSERT: begin
              state_r <= iss_pkg::S_FIN;
              if (full) begin
                st_r <= iss_pkg::ST_FULL;
              end else begin
                st_r   <= iss_pkg::ST_OK;
                head_r <= head_dec;
                held_r <= held_r + CW'(1);
              end
            end
            iss_pkg::FUNC_EXCLUDE: begin
              st_r    <= iss_pkg::ST_OK;
              n_r     <= held_r;
              c_r     <= '0;
              w_r     <= '0;
              state_r <= iss_pkg::S_XRD;
            end
            default: begin
              if (idx_x < held_x) begin
                st_r    <= iss_pkg::ST_OK;
                state_r <= iss_pkg::S_RWAIT;
              end else begin
                st_r    <= iss_pkg::ST_IDX;
                state_r <= iss_pkg::S_FIN;
              end
            end
          endcase
        end
        iss_pkg::S_RWAIT: begin
          eb_r    <= rb;
          ee_r    <= re;
          state_r <= iss_pkg::S_FIN;
        end
        iss_pkg::S_XRD: begin
          if (c_r == n_r) begin
            held_r  <= w_r;
            head_r  <= '0;
            bank_r  <= ~bank_r;
            state_r <= iss_pkg::S_FIN;
          end else begin
            state_r <= iss_pkg::S_XEV;
          end
        end
        iss_pkg::S_XEV: begin
          spl_e_r <= cmp_e;
          if (!c_all) begin
            w_r <= w_r + CW'(1);
          end
          if (c_split && room) begin
            state_r <= iss_pkg::S_XSPL;
          end else begin
            c_r     <= c_r + CW'(1);
            state_r <= iss_pkg::S_XRD;
          end
          if (c_split && !room) begin
            st_r <= iss_pkg::ST_FULL;
          end
        end
        iss_pkg::S_XSPL: begin
          spl_e_r <= cmp_e;
          if (!c_all) begin
            w_r <= w_r + CW'(1);
          end
          if (c_split && room) begin
            state_r <= iss_pkg::S_XSPL;
          end else begin
            c_r     <= c_r + CW'(1);
            state_r <= iss_pkg::S_XRD;
          end
          if (c_split && !room) begin
            st_r <= iss_pkg::ST_FULL;
          end
        end
        iss_pkg::S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {cnt6, ee_x[31:0], eb_x[31:0], st_r};
            state_r     <= iss_pkg::S_IDLE;
          end
        end
        default: state_r <= iss_pkg::S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/iss_ram.sv
`default_nettype none
module iss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
